// File: sv/se2_nearest_and_radius_search_assert.svh
// ----------------------------------------------------------------------------
// se2_nearest_and_radius_search_assert.svh
// Assertion macros used by the nearest and radius search RTL.
// ----------------------------------------------------------------------------
`ifndef SE2_NEAREST_AND_RADIUS_SEARCH_ASSERT_SVH
`define SE2_NEAREST_AND_RADIUS_SEARCH_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define SE2NRS_ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define SE2NRS_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: sv/se2nrs_pkg.sv
// ----------------------------------------------------------------------------
// se2nrs_pkg
// Types, codes and constants of the SE(2) nearest and radius search block.
// ----------------------------------------------------------------------------
package se2nrs_pkg;

    // Store size and field widths
    localparam int DEFAULT_MAX_NODES = 32;
    localparam int IDX_W             = 6;
    localparam int DIST_W            = 35;
    localparam int CFG_IDX_W         = 8;
    localparam int CFG_DATA_W        = 24;

    // Register reset values
    localparam logic [15:0] RADIUS_RST  = 16'd256;
    localparam logic [23:0] ANGLE_W_RST = 24'd1011;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_W = 8'd1;

    // Request commands
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_ACK      = 2'd0;
    localparam logic [1:0] KIND_NEIGHBOR = 2'd1;
    localparam logic [1:0] KIND_SUMMARY  = 2'd2;

    // Result status
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [15:0]        heading;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [IDX_W-1:0]  node_index;
        logic [DIST_W-1:0] dist_sq;
        logic [1:0]        status;
        logic              last;
    } out_item_t;

    // One stored pose, 48 bits
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        h;
    } node_t;

    // Token that follows a node through the distance pipeline
    typedef struct packed {
        logic             vld;
        logic             lst;
        logic [IDX_W-1:0] idx;
    } tag_t;

endpackage

// File: sv/se2nrs_ram.sv
// ----------------------------------------------------------------------------
// se2nrs_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module se2nrs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write, and hold read data unless a read is enabled
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/se2nrs_dist.sv
// ----------------------------------------------------------------------------
// se2nrs_dist
// Four-stage weighted squared distance pipeline between a node and a query.
// ----------------------------------------------------------------------------
module se2nrs_dist (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  se2nrs_pkg::node_t            node_i,
    input  se2nrs_pkg::tag_t             tag_i,
    input  se2nrs_pkg::node_t            query_i,
    input  logic [23:0]                  weight_i,
    output logic [se2nrs_pkg::DIST_W-1:0] dist_o,
    output se2nrs_pkg::tag_t             tag_o
);

    // Stage A: absolute differences and wrapped heading magnitude
    se2nrs_pkg::tag_t tag_a_reg;
    logic [15:0]      adx_reg, ady_reg, mh_reg;
    logic signed [16:0] dx, dy;
    logic [15:0]      dh;

    // Stage B: squares
    se2nrs_pkg::tag_t tag_b_reg;
    logic [31:0]      dx2_reg, dy2_reg;
    logic [30:0]      mh2_reg;
    logic [31:0]      mh2_full;

    // Stage C: weighted angle term and planar sum
    se2nrs_pkg::tag_t tag_c_reg;
    logic [32:0]      sxy_reg;
    logic [30:0]      ang_reg;
    logic [54:0]      ang_prod;

    // Stage D: total
    se2nrs_pkg::tag_t               tag_d_reg;
    logic [se2nrs_pkg::DIST_W-1:0] dist_reg;

    always_comb begin
        dx = {node_i.x[15], node_i.x} - {query_i.x[15], query_i.x};
        dy = {node_i.y[15], node_i.y} - {query_i.y[15], query_i.y};
        dh = node_i.h - query_i.h;
        mh2_full = 32'(mh_reg) * 32'(mh_reg);
        ang_prod = 55'(mh2_reg) * 55'(weight_i);
    end

    // Advance tokens; control bits only need reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            tag_c_reg <= '0;
            tag_d_reg <= '0;
        end else if (en) begin
            tag_a_reg <= tag_i;
            tag_b_reg <= tag_a_reg;
            tag_c_reg <= tag_b_reg;
            tag_d_reg <= tag_c_reg;
        end
    end

    // Advance payload; the sum stays below 2^35 so no clamp is needed
    always_ff @(posedge aclk) begin
        if (en) begin
            adx_reg  <= dx[16] ? 16'(-dx) : dx[15:0];
            ady_reg  <= dy[16] ? 16'(-dy) : dy[15:0];
            mh_reg   <= dh[15] ? 16'(-dh) : dh;
            dx2_reg  <= 32'(adx_reg) * 32'(adx_reg);
            dy2_reg  <= 32'(ady_reg) * 32'(ady_reg);
            mh2_reg  <= mh2_full[30:0];
            sxy_reg  <= 33'(dx2_reg) + 33'(dy2_reg);
            ang_reg  <= ang_prod[54:24];
            dist_reg <= se2nrs_pkg::DIST_W'(sxy_reg) + se2nrs_pkg::DIST_W'(ang_reg);
        end
    end

    assign dist_o = dist_reg;
    assign tag_o  = tag_d_reg;

endmodule

// File: sv/se2_nearest_and_radius_search.sv
// ----------------------------------------------------------------------------
// se2_nearest_and_radius_search
// Node store with weighted SE(2) radius and nearest-neighbor search.
// ----------------------------------------------------------------------------
// Insert and clear requests, and a query on an empty store, offer their result
// from ST_ACK once the result register can advance, and the block takes the
// next request after that. A query on N stored nodes reads the node memory
// once per stored node, one node per cycle while the result port does not
// stall. Each read passes the memory read register, the four distance stages
// and the compare stage; the last node then moves the block to ST_SUM, which
// offers the summary, and the next request is taken after the summary is
// offered. A neighbor result is produced for each node within the configured
// radius and a summary with the nearest node closes every query; a stalled
// result port stalls the scan. Requests are taken one at a time. The node
// memory has no reset and needs no clearing pass: only entries below the node
// count are ever read.
// ----------------------------------------------------------------------------
`include "se2_nearest_and_radius_search_assert.svh"

module se2_nearest_and_radius_search #(
    parameter int MAX_NODES = se2nrs_pkg::DEFAULT_MAX_NODES
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  se2nrs_pkg::in_item_t              s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output se2nrs_pkg::out_item_t             m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [se2nrs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [se2nrs_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACK,
        ST_SCAN,
        ST_DRAIN,
        ST_SUM
    } state_t;

    state_t                         state_reg, state_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [AW-1:0]                  issue_reg, issue_next;
    se2nrs_pkg::node_t              query_reg, query_next;
    logic [31:0]                    r2_reg, r2_next;
    se2nrs_pkg::tag_t               tag1_reg, tag1_next;
    se2nrs_pkg::out_item_t          ack_reg, ack_next;
    se2nrs_pkg::out_item_t          out_reg, out_next;
    logic                           out_vld_reg, out_vld_next;
    logic [se2nrs_pkg::DIST_W-1:0]  best_reg, best_next;
    logic [se2nrs_pkg::IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [15:0]                    radius_reg;
    logic [23:0]                    weight_reg;

    logic                           adv;
    logic                           in_fire;
    logic                           issue_last;
    logic                           full;
    logic                           wr_en;
    logic                           rd_en;
    logic [47:0]                    rd_data;
    logic [se2nrs_pkg::DIST_W-1:0]  node_dist;
    se2nrs_pkg::tag_t               dist_tag;
    logic                           in_radius;
    logic                           better;
    se2nrs_pkg::node_t              in_node;

    assign adv        = !out_vld_reg || m_ready;
    assign s_ready    = (state_reg == ST_IDLE);
    assign in_fire    = s_valid && s_ready;
    assign full       = (count_reg >= CW'(MAX_NODES));
    assign issue_last = (CW'(issue_reg) == count_reg - CW'(1));
    assign cfg_ready  = 1'b1;

    // Write only while idle; reads happen only in a later scan, so no overlap
    assign wr_en   = in_fire && (s_data.cmd == se2nrs_pkg::CMD_INSERT) && !full;
    assign rd_en   = adv && (state_reg == ST_SCAN);
    assign in_node = '{x: s_data.pos_x, y: s_data.pos_y, h: s_data.heading};

    se2nrs_ram #(
        .WIDTH (48),
        .DEPTH (MAX_NODES)
    ) u_node_ram (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (in_node),
        .rd_en   (rd_en),
        .rd_addr (issue_reg),
        .rd_data (rd_data)
    );

    se2nrs_dist u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .node_i   (se2nrs_pkg::node_t'(rd_data)),
        .tag_i    (tag1_reg),
        .query_i  (query_reg),
        .weight_i (weight_reg),
        .dist_o   (node_dist),
        .tag_o    (dist_tag)
    );

    assign in_radius = (node_dist <= se2nrs_pkg::DIST_W'(r2_reg));
    assign better    = (dist_tag.idx == '0) || (node_dist < best_reg);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= se2nrs_pkg::RADIUS_RST;
            weight_reg <= se2nrs_pkg::ANGLE_W_RST;
        end else if (cfg_valid) begin
            if (cfg_index == se2nrs_pkg::REG_RADIUS) begin
                radius_reg <= cfg_data[15:0];
            end else if (cfg_index == se2nrs_pkg::REG_ANGLE_W) begin
                weight_reg <= cfg_data;
            end
        end
    end

    // Sequencer, scan control, compare stage and output register
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        issue_next    = issue_reg;
        query_next    = query_reg;
        r2_next       = r2_reg;
        ack_next      = ack_reg;
        out_next      = out_reg;
        out_vld_next  = out_vld_reg && !m_ready;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        tag1_next     = tag1_reg;

        // Issue one memory read per advance while scanning
        if (adv) begin
            tag1_next.vld = (state_reg == ST_SCAN);
            tag1_next.lst = issue_last;
            tag1_next.idx = se2nrs_pkg::IDX_W'(issue_reg);
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    ack_next.kind       = se2nrs_pkg::KIND_ACK;
                    ack_next.node_index = '0;
                    ack_next.dist_sq    = '0;
                    ack_next.status     = se2nrs_pkg::STAT_OK;
                    ack_next.last       = 1'b1;
                    case (s_data.cmd)
                        se2nrs_pkg::CMD_INSERT: begin
                            if (full) begin
                                ack_next.status = se2nrs_pkg::STAT_FULL;
                            end else begin
                                ack_next.node_index = se2nrs_pkg::IDX_W'(count_reg);
                                count_next          = count_reg + CW'(1);
                            end
                            state_next = ST_ACK;
                        end
                        se2nrs_pkg::CMD_CLEAR: begin
                            count_next = '0;
                            state_next = ST_ACK;
                        end
                        se2nrs_pkg::CMD_QUERY: begin
                            if (count_reg == '0) begin
                                ack_next.kind   = se2nrs_pkg::KIND_SUMMARY;
                                ack_next.status = se2nrs_pkg::STAT_EMPTY;
                                state_next      = ST_ACK;
                            end else begin
                                query_next = in_node;
                                r2_next    = 32'(radius_reg) * 32'(radius_reg);
                                issue_next = '0;
                                state_next = ST_SCAN;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ACK: begin
                if (adv) begin
                    out_next     = ack_reg;
                    out_vld_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (adv) begin
                    issue_next = AW'(issue_reg + AW'(1));
                    if (issue_last) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                state_next = ST_DRAIN;
            end
            ST_SUM: begin
                if (adv) begin
                    out_next.kind       = se2nrs_pkg::KIND_SUMMARY;
                    out_next.node_index = best_idx_reg;
                    out_next.dist_sq    = best_reg;
                    out_next.status     = se2nrs_pkg::STAT_OK;
                    out_next.last       = 1'b1;
                    out_vld_next        = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Compare stage: emit neighbors, track nearest, close the scan
        if (adv && dist_tag.vld) begin
            if (better) begin
                best_next     = node_dist;
                best_idx_next = dist_tag.idx;
            end
            if (in_radius) begin
                out_next.kind       = se2nrs_pkg::KIND_NEIGHBOR;
                out_next.node_index = dist_tag.idx;
                out_next.dist_sq    = node_dist;
                out_next.status     = se2nrs_pkg::STAT_OK;
                out_next.last       = 1'b0;
                out_vld_next        = 1'b1;
            end
            if (dist_tag.lst) begin
                state_next = ST_SUM;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            out_vld_reg <= 1'b0;
            tag1_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            out_vld_reg  <= out_vld_next;
            tag1_reg     <= tag1_next;
            issue_reg    <= issue_next;
            query_reg    <= query_next;
            r2_reg       <= r2_next;
            ack_reg      <= ack_next;
            out_reg      <= out_next;
            best_reg     <= best_next;
            best_idx_reg <= best_idx_next;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    // Assertions
    `SE2NRS_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= CW'(MAX_NODES), "node count above store size")
    `SE2NRS_ASSERT_IMPLY(a_nbr_in_radius, aclk, aresetn, m_valid && (m_data.kind == se2nrs_pkg::KIND_NEIGHBOR), m_data.dist_sq <= se2nrs_pkg::DIST_W'(r2_reg), "neighbor result outside radius")
    `SE2NRS_ASSERT_IMPLY(a_nbr_index, aclk, aresetn, m_valid && (m_data.kind == se2nrs_pkg::KIND_NEIGHBOR), CW'(m_data.node_index) < count_reg, "neighbor index beyond node count")
    `SE2NRS_ASSERT_IMPLY(a_sum_drained, aclk, aresetn, state_reg == ST_SUM, !tag1_reg.vld && !dist_tag.vld, "summary while nodes still in flight")

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the SE(2) nearest and radius search block. A driver
// sends insert, query and clear requests from a backlog, a predictor tracks
// the node store and the two registers and lists the results each request
// must give, and a monitor compares every result with the oldest listed one.
// Both sides idle in random bursts outside the final stretch; register writes
// happen only once the block has drained between phases.
// ----------------------------------------------------------------------------

module testbench;

    localparam int MAX_NODES      = se2nrs_pkg::DEFAULT_MAX_NODES;
    localparam int LONG_HOLD      = 400;
    localparam int SETTLE_CYCLES  = 64;
    localparam int WATCHDOG_LIMIT = 4000;

    // Command code the block must ignore
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Register indexes the block must ignore
    localparam logic [se2nrs_pkg::CFG_IDX_W-1:0] REG_SPARE    = 8'd2;
    localparam logic [se2nrs_pkg::CFG_IDX_W-1:0] REG_TOP_SLOT = 8'hFF;

    localparam logic [se2nrs_pkg::DIST_W-1:0] DIST_CLAMP = '1;

    logic                              aclk      = 1'b0;
    logic                              aresetn   = 1'b0;
    logic                              s_valid   = 1'b0;
    logic                              s_ready;
    se2nrs_pkg::in_item_t              s_data    = '0;
    logic                              m_valid;
    logic                              m_ready   = 1'b0;
    se2nrs_pkg::out_item_t             m_data;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [se2nrs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [se2nrs_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // Predicted block state
    se2nrs_pkg::node_t node_store [MAX_NODES];
    int                stored_cnt = 0;
    logic [15:0]       radius_cfg = se2nrs_pkg::RADIUS_RST;
    logic [23:0]       weight_cfg = se2nrs_pkg::ANGLE_W_RST;

    se2nrs_pkg::in_item_t  backlog[$];
    se2nrs_pkg::out_item_t due_results[$];

    int items_queued = 0;
    int fail_cnt     = 0;
    int send_gap     = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;
    bit idle_on      = 1'b1;
    bit hold_arm     = 1'b0;
    bit hold_done    = 1'b0;

    se2_nearest_and_radius_search u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Squared weighted pose distance, heading difference wrapped to one turn
    function automatic logic [se2nrs_pkg::DIST_W-1:0] pose_dist_sq(
            se2nrs_pkg::node_t n, se2nrs_pkg::in_item_t q);
        longint            dx;
        longint            dy;
        longint            mh;
        logic [15:0]       dh;
        longint unsigned   sum;
        dx  = longint'($signed(n.x)) - longint'($signed(q.pos_x));
        dy  = longint'($signed(n.y)) - longint'($signed(q.pos_y));
        dh  = n.h - q.heading;
        mh  = dh[15] ? (65536 - longint'(dh)) : longint'(dh);
        sum = longint'(dx * dx + dy * dy) + ((mh * mh * longint'(weight_cfg)) >> 24);
        return (sum > DIST_CLAMP) ? DIST_CLAMP : sum[se2nrs_pkg::DIST_W-1:0];
    endfunction

    function automatic se2nrs_pkg::out_item_t result_item(logic [1:0] rkind, int idx,
                                                          logic [se2nrs_pkg::DIST_W-1:0] dval,
                                                          logic [1:0] rstat, logic rlast);
        se2nrs_pkg::out_item_t r;
        r.kind       = rkind;
        r.node_index = idx[se2nrs_pkg::IDX_W-1:0];
        r.dist_sq    = dval;
        r.status     = rstat;
        r.last       = rlast;
        return r;
    endfunction

    // Append one result to the list of those still due
    function automatic void add_due(se2nrs_pkg::out_item_t r);
        due_results = {due_results, r};
    endfunction

    // Update the store and list the results of one accepted request
    function automatic void predict_request(se2nrs_pkg::in_item_t req);
        longint unsigned                r2;
        logic [se2nrs_pkg::DIST_W-1:0] d;
        logic [se2nrs_pkg::DIST_W-1:0] best;
        int                             best_i;
        se2nrs_pkg::node_t              pose;
        best   = '0;
        best_i = 0;
        case (req.cmd)
            se2nrs_pkg::CMD_INSERT: begin
                if (stored_cnt >= MAX_NODES) begin
                    add_due(result_item(se2nrs_pkg::KIND_ACK, 0, '0,
                                        se2nrs_pkg::STAT_FULL, 1'b1));
                end else begin
                    pose.x = req.pos_x;
                    pose.y = req.pos_y;
                    pose.h = req.heading;
                    node_store[stored_cnt] = pose;
                    add_due(result_item(se2nrs_pkg::KIND_ACK, stored_cnt, '0,
                                        se2nrs_pkg::STAT_OK, 1'b1));
                    stored_cnt++;
                end
            end
            se2nrs_pkg::CMD_CLEAR: begin
                stored_cnt = 0;
                add_due(result_item(se2nrs_pkg::KIND_ACK, 0, '0, se2nrs_pkg::STAT_OK, 1'b1));
            end
            se2nrs_pkg::CMD_QUERY: begin
                r2 = longint'(radius_cfg) * longint'(radius_cfg);
                if (stored_cnt == 0) begin
                    add_due(result_item(se2nrs_pkg::KIND_SUMMARY, 0, '0,
                                        se2nrs_pkg::STAT_EMPTY, 1'b1));
                end else begin
                    // Scan in index order; ties keep the lower index
                    for (int i = 0; i < stored_cnt; i++) begin
                        d = pose_dist_sq(node_store[i], req);
                        if (d <= r2)
                            add_due(result_item(se2nrs_pkg::KIND_NEIGHBOR, i, d,
                                                se2nrs_pkg::STAT_OK, 1'b0));
                        if (i == 0 || d < best) begin
                            best   = d;
                            best_i = i;
                        end
                    end
                    add_due(result_item(se2nrs_pkg::KIND_SUMMARY, best_i, best,
                                        se2nrs_pkg::STAT_OK, 1'b1));
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                predict_request(s_data);
            // Hold a request that is still waiting, else idle or send the next
            if (s_valid && !s_ready) begin
                s_valid <= 1'b1;
            end else if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(1, 16) - 1;
                s_valid <= 1'b0;
            end else if (backlog.size() > 0) begin
                s_data  <= backlog.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------
    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    task automatic check_result(se2nrs_pkg::out_item_t got);
        se2nrs_pkg::out_item_t want;
        if (due_results.size() == 0) begin
            $error("unexpected result: kind %0d node_index %0d dist_sq %0d",
                   got.kind, got.node_index, got.dist_sq);
            fail_cnt++;
        end else begin
            want = due_results.pop_front();
            check_field("kind", 64'(want.kind), 64'(got.kind));
            check_field("node_index", 64'(want.node_index), 64'(got.node_index));
            check_field("dist_sq", 64'(want.dist_sq), 64'(got.dist_sq));
            check_field("status", 64'(want.status), 64'(got.status));
            check_field("last", 64'(want.last), 64'(got.last));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                check_result(m_data);
            // Stall in random bursts, once for a long stretch on request
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_arm && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                hold_left = $urandom_range(1, 16) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Abort when no channel moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[se2_nearest_and_radius_search] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic queue_req(logic [1:0] cmd, int x, int y, int h);
        se2nrs_pkg::in_item_t r;
        r.cmd     = cmd;
        r.pos_x   = x[15:0];
        r.pos_y   = y[15:0];
        r.heading = h[15:0];
        backlog = {backlog, r};
        if (cmd != CMD_UNUSED)
            items_queued++;
    endtask

    function automatic int jitter(int spread);
        return int'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    // Poses scattered around one center so that queries find neighbors
    task automatic queue_cluster(int n_ins, int n_qry, int spread, int hspread, bit wipe);
        int cx;
        int cy;
        int ch;
        cx = int'($urandom_range(0, 60000)) - 30000;
        cy = int'($urandom_range(0, 60000)) - 30000;
        ch = int'($urandom_range(0, 65535));
        if (wipe)
            queue_req(se2nrs_pkg::CMD_CLEAR, $urandom, $urandom, $urandom);
        repeat (n_ins)
            queue_req(se2nrs_pkg::CMD_INSERT, cx + jitter(spread), cy + jitter(spread),
                      ch + jitter(hspread));
        repeat (n_qry)
            queue_req(se2nrs_pkg::CMD_QUERY, cx + jitter(spread), cy + jitter(spread),
                      ch + jitter(hspread));
    endtask

    task automatic queue_noise(int n);
        repeat (n)
            queue_req(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
    endtask

    // Mostly well-formed clusters, some noise, until the request total is reached
    task automatic fill_phase(int target, int spread, int hspread);
        int n_ins;
        while (items_queued < target) begin
            if ($urandom_range(0, 3) == 0) begin
                queue_noise($urandom_range(1, 3));
            end else begin
                n_ins = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 34)
                                                    : $urandom_range(1, 6);
                queue_cluster(n_ins, $urandom_range(1, 4), $urandom_range(0, spread),
                              $urandom_range(0, hspread), $urandom_range(0, 2) == 0);
            end
        end
    endtask

    // Wait until every request is sent and every result has come back
    task automatic wait_drained();
        while (backlog.size() != 0 || s_valid || due_results.size() != 0)
            @(negedge aclk);
    endtask

    task automatic end_phase();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [se2nrs_pkg::CFG_IDX_W-1:0] idx,
                             logic [se2nrs_pkg::CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        if (idx == se2nrs_pkg::REG_RADIUS)
            radius_cfg = val[15:0];
        else if (idx == se2nrs_pkg::REG_ANGLE_W)
            weight_cfg = val;
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed requests at the reset register values
        queue_req(se2nrs_pkg::CMD_QUERY, 0, 0, 0);                  // empty store
        queue_req(CMD_UNUSED, -1, -1, 65535);                       // ignored command
        queue_req(se2nrs_pkg::CMD_CLEAR, 0, 0, 0);
        queue_req(se2nrs_pkg::CMD_INSERT, -32768, -32768, 0);
        queue_req(se2nrs_pkg::CMD_INSERT, 32767, 32767, 32768);
        queue_req(se2nrs_pkg::CMD_INSERT, 0, 0, 65535);
        queue_req(se2nrs_pkg::CMD_INSERT, 0, 0, 65535);             // duplicate: nearest tie
        queue_req(se2nrs_pkg::CMD_INSERT, 256, 0, 0);               // exactly on the radius
        queue_req(se2nrs_pkg::CMD_INSERT, 0, 257, 0);               // just outside it
        queue_req(se2nrs_pkg::CMD_QUERY, 0, 0, 0);
        queue_req(se2nrs_pkg::CMD_QUERY, -32768, 32767, 32767);
        queue_req(se2nrs_pkg::CMD_QUERY, 32767, -32768, 32768);     // half-turn heading gap
        queue_req(se2nrs_pkg::CMD_QUERY, 0, 0, 32768);
        queue_req(se2nrs_pkg::CMD_CLEAR, -1, -1, 65535);
        queue_req(se2nrs_pkg::CMD_QUERY, 0, 0, 0);                  // empty after clear
        queue_req(se2nrs_pkg::CMD_INSERT, -1, -1, 65535);
        queue_req(se2nrs_pkg::CMD_QUERY, -1, -1, 65535);            // exact match
        queue_req(se2nrs_pkg::CMD_QUERY, 1, -1, 0);                 // heading wraps across zero
        end_phase();

        // Widest radius and weight; fill the store and overflow it
        write_reg(se2nrs_pkg::REG_RADIUS, 24'hFFFFFF);
        write_reg(se2nrs_pkg::REG_ANGLE_W, 24'hFFFFFF);
        write_reg(REG_SPARE, 24'($urandom));
        write_reg(REG_TOP_SLOT, 24'($urandom));
        queue_req(se2nrs_pkg::CMD_CLEAR, 0, 0, 0);
        repeat (MAX_NODES + 2)
            queue_req(se2nrs_pkg::CMD_INSERT, $urandom, $urandom, $urandom);
        repeat (3)
            queue_req(se2nrs_pkg::CMD_QUERY, $urandom, $urandom, $urandom);
        fill_phase(100, 2000, 4000);
        end_phase();

        // Zero radius and weight: only exact position matches are neighbors
        write_reg(se2nrs_pkg::REG_RADIUS, 24'h000000);
        write_reg(se2nrs_pkg::REG_ANGLE_W, 24'h000000);
        fill_phase(140, 2, 2);
        end_phase();

        // Long result stall while the driver keeps offering queries
        write_reg(se2nrs_pkg::REG_RADIUS, 24'($urandom_range(64, 1024)));
        write_reg(se2nrs_pkg::REG_ANGLE_W, 24'($urandom));
        queue_cluster(10, 12, 300, 200, 1'b1);
        hold_arm = 1'b1;
        fill_phase(190, 512, 1024);
        end_phase();

        // Upper data bits of the radius write are dropped
        write_reg(se2nrs_pkg::REG_RADIUS, {8'($urandom), 16'($urandom_range(128, 2048))});
        write_reg(se2nrs_pkg::REG_ANGLE_W, se2nrs_pkg::ANGLE_W_RST);
        fill_phase(230, 1024, 8000);
        end_phase();

        // Final stretch at full rate on both sides
        idle_on = 1'b0;
        write_reg(se2nrs_pkg::REG_RADIUS, {8'h00, se2nrs_pkg::RADIUS_RST});
        write_reg(se2nrs_pkg::REG_ANGLE_W, 24'($urandom));
        fill_phase(275, 400, 2000);
        end_phase();

        if (fail_cnt == 0)
            $display("[se2_nearest_and_radius_search] OK");
        else
            $display("[se2_nearest_and_radius_search] ERROR");
        $finish;
    end

endmodule
